>>> rtl/hta_pkg.sv
// Shared constants, types and the key usage to ASCII translation for the text report decoder.
package hta_pkg;

  localparam int LineLen   = 26;
  localparam int ReportLen = 8;
  localparam int KeySlots  = 6;

  localparam logic [7:0] LfChar = 8'd10;
  localparam logic [7:0] CrChar = 8'd13;

  localparam logic [0:0] KindReport = 1'b0;
  localparam logic [0:0] KindChar   = 1'b1;

  // One completed line: the decoded report, which key slots hold a newly pressed key
  // with a character, and the character of each slot.
  typedef struct packed {
    logic [ReportLen-1:0][7:0] report;
    logic [KeySlots-1:0]       fresh;
    logic [KeySlots-1:0][6:0]  code;
  } hta_line_t;

  // Returns 0 when the usage has no translation in the selected table.
  function automatic logic [6:0] key_to_ascii(input logic [7:0] key, input logic shifted);
    logic [6:0] a;
    a = 7'd0;
    if (key >= 8'd4 && key <= 8'd29) begin
      a = shifted ? 7'(key + 8'd61) : 7'(key + 8'd93);
    end else begin
      case (key)
        8'd30:   a = shifted ? 7'd33  : 7'd49;
        8'd31:   a = shifted ? 7'd64  : 7'd50;
        8'd32:   a = shifted ? 7'd35  : 7'd51;
        8'd33:   a = shifted ? 7'd36  : 7'd52;
        8'd34:   a = shifted ? 7'd37  : 7'd53;
        8'd35:   a = shifted ? 7'd94  : 7'd54;
        8'd36:   a = shifted ? 7'd38  : 7'd55;
        8'd37:   a = shifted ? 7'd42  : 7'd56;
        8'd38:   a = shifted ? 7'd40  : 7'd57;
        8'd39:   a = shifted ? 7'd41  : 7'd48;
        8'd40:   a = shifted ? 7'd0   : 7'd10;
        8'd42:   a = shifted ? 7'd0   : 7'd8;
        8'd43:   a = shifted ? 7'd0   : 7'd9;
        8'd44:   a = shifted ? 7'd0   : 7'd32;
        8'd45:   a = shifted ? 7'd95  : 7'd45;
        8'd46:   a = shifted ? 7'd43  : 7'd61;
        8'd47:   a = shifted ? 7'd123 : 7'd91;
        8'd48:   a = shifted ? 7'd125 : 7'd93;
        8'd49:   a = shifted ? 7'd124 : 7'd92;
        8'd51:   a = shifted ? 7'd58  : 7'd59;
        8'd52:   a = shifted ? 7'd34  : 7'd39;
        8'd53:   a = shifted ? 7'd126 : 7'd96;
        8'd54:   a = shifted ? 7'd60  : 7'd44;
        8'd55:   a = shifted ? 7'd62  : 7'd46;
        8'd56:   a = shifted ? 7'd63  : 7'd47;
        // Keypad keys translate the same with or without shift.
        8'd84:   a = 7'd47;
        8'd85:   a = 7'd42;
        8'd86:   a = 7'd45;
        8'd87:   a = 7'd43;
        8'd98:   a = 7'd48;
        8'd99:   a = 7'd46;
        default: a = 7'd0;
      endcase
      if (key >= 8'd89 && key <= 8'd97) begin
        a = 7'(key - 8'd40);
      end
    end
    return a;
  endfunction

endpackage

>>> rtl/hid_text_report_to_ascii.sv
// Top level: text line to keyboard report decoder with new-key ASCII output.
// The block takes one character per cycle while in_ready is high. A line is LF, CR
// and 24 characters holding eight hex pairs; the 26th character completes it and
// produces one result with the decoded report, followed by one result per newly
// pressed key that has an ASCII translation, so 1 to 7 results that leave the
// output register one per cycle while out_ready is high. As they drain, characters
// of the next line are still taken; only its 26th character is held off until the
// last result of the previous line is taken. At full speed the drain of a line's
// results overlaps the next line's input; last_of_run marks each line's final result.
module hid_text_report_to_ascii (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       result_kind,
  output logic [7:0] modifier_bits,
  output logic [7:0] reserved_byte,
  output logic [7:0] key_slot_a,
  output logic [7:0] key_slot_b,
  output logic [7:0] key_slot_c,
  output logic [7:0] key_slot_d,
  output logic [7:0] key_slot_e,
  output logic [7:0] key_slot_f,
  output logic [6:0] ascii_char,
  output logic       last_of_run
);

  logic               take;
  logic               at_end;
  logic               done;
  hta_pkg::hta_line_t new_line;

  hta_pkg::hta_line_t held_line;
  logic               report_pending;
  logic [5:0]         key_pending;
  logic [5:0]         key_pending_next;
  logic [2:0]         pick;
  logic               busy;

  assign busy     = report_pending || (key_pending != 6'd0);
  assign in_ready = !(busy && at_end);
  assign take     = in_valid && in_ready;

  hta_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx_byte),
    .at_end  (at_end),
    .done    (done),
    .line    (new_line)
  );

  always_comb begin
    pick = 3'd0;
    for (int s = hta_pkg::KeySlots - 1; s >= 0; s--) begin
      if (key_pending[s]) begin
        pick = 3'(s);
      end
    end
  end

  // Clearing the lowest set bit retires the key result now on the port.
  assign key_pending_next = key_pending & (key_pending - 6'd1);

  assign out_valid   = busy;
  assign result_kind = report_pending ? hta_pkg::KindReport : hta_pkg::KindChar;

  always_comb begin
    modifier_bits = 8'd0;
    reserved_byte = 8'd0;
    key_slot_a    = 8'd0;
    key_slot_b    = 8'd0;
    key_slot_c    = 8'd0;
    key_slot_d    = 8'd0;
    key_slot_e    = 8'd0;
    key_slot_f    = 8'd0;
    ascii_char    = 7'd0;
    if (report_pending) begin
      modifier_bits = held_line.report[0];
      reserved_byte = held_line.report[1];
      key_slot_a    = held_line.report[2];
      key_slot_b    = held_line.report[3];
      key_slot_c    = held_line.report[4];
      key_slot_d    = held_line.report[5];
      key_slot_e    = held_line.report[6];
      key_slot_f    = held_line.report[7];
      last_of_run   = (key_pending == 6'd0);
    end else begin
      ascii_char    = held_line.code[pick];
      last_of_run   = (key_pending_next == 6'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      held_line <= new_line;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report_pending <= 1'b0;
      key_pending    <= '0;
    end else if (done) begin
      report_pending <= 1'b1;
      key_pending    <= new_line.fresh;
    end else if (out_valid && out_ready) begin
      if (report_pending) begin
        report_pending <= 1'b0;
      end else begin
        key_pending <= key_pending_next;
      end
    end
  end

endmodule

>>> rtl/hta_parse.sv
// Line parser: checks the LF CR preamble, decodes the hex pairs and finds the new keys.
module hta_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        rx_byte,
  output logic              at_end,
  output logic              done,
  output hta_pkg::hta_line_t line
);

  logic [4:0]       text_position;
  logic [1:0]       digit_phase;
  logic [2:0]       byte_slot;
  logic [3:0]       first_digit_value;
  logic             first_digit_ok;
  logic [7:0][7:0]  current_report;
  logic [5:0][7:0]  previous_keys;

  logic       hex_ok;
  logic [3:0] hex_val;
  logic       shifted;
  logic [7:0] pair_value;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (rx_byte >= 8'h30 && rx_byte <= 8'h39) begin
      hex_val = rx_byte[3:0];
    end else if ((rx_byte >= 8'h61 && rx_byte <= 8'h66) ||
                 (rx_byte >= 8'h41 && rx_byte <= 8'h46)) begin
      hex_val = 4'(rx_byte[2:0] + 3'd1) + 4'd8;
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    pair_value = 8'd0;
    if (first_digit_ok) begin
      pair_value = hex_ok ? {first_digit_value, hex_val} : {4'd0, first_digit_value};
    end
  end

  assign at_end = (text_position == 5'(hta_pkg::LineLen - 1));
  assign done   = take && at_end;

  // The last character of a line is a separator, so the report is already complete here.
  assign shifted = current_report[0][1] | current_report[0][5];

  always_comb begin
    logic held;
    line.report = current_report;
    for (int s = 0; s < hta_pkg::KeySlots; s++) begin
      held = 1'b0;
      for (int k = 0; k < hta_pkg::KeySlots; k++) begin
        held = held | (previous_keys[k] == current_report[2 + s]);
      end
      line.code[s]  = hta_pkg::key_to_ascii(current_report[2 + s], shifted);
      line.fresh[s] = (current_report[2 + s] != 8'd0) && !held && (line.code[s] != 7'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_position     <= '0;
      digit_phase       <= '0;
      byte_slot         <= '0;
      first_digit_value <= '0;
      first_digit_ok    <= 1'b0;
      current_report    <= '0;
      previous_keys     <= '0;
    end else if (take) begin
      if (text_position == 5'd0) begin
        text_position <= (rx_byte == hta_pkg::LfChar) ? 5'd1 : 5'd0;
        digit_phase   <= '0;
        byte_slot     <= '0;
      end else if (text_position == 5'd1) begin
        text_position <= (rx_byte == hta_pkg::CrChar) ? 5'd2 : 5'd1;
        digit_phase   <= '0;
        byte_slot     <= '0;
      end else if (at_end) begin
        for (int s = 0; s < hta_pkg::KeySlots; s++) begin
          previous_keys[s] <= current_report[2 + s];
        end
        current_report    <= '0;
        text_position     <= '0;
        digit_phase       <= '0;
        byte_slot         <= '0;
        first_digit_value <= '0;
        first_digit_ok    <= 1'b0;
      end else begin
        text_position <= text_position + 5'd1;
        case (digit_phase)
          2'd0: begin
            first_digit_ok    <= hex_ok;
            first_digit_value <= hex_ok ? hex_val : 4'd0;
            digit_phase       <= 2'd1;
          end
          2'd1: begin
            current_report[byte_slot] <= pair_value;
            digit_phase               <= 2'd2;
          end
          default: begin
            digit_phase <= 2'd0;
            byte_slot   <= byte_slot + 3'd1;
          end
        endcase
      end
    end
  end

endmodule
